>>> hw/rtl/rvt_pkg.sv
// Shared constants, types and helpers for the return volatility and trend unit.
`default_nettype none
package rvt_pkg;

   // Ring geometry
   localparam int WINDOW = 100;
   localparam int SLOT_W = (WINDOW > 1) ? $clog2(WINDOW) : 1;
   localparam int CNT_W  = $clog2(WINDOW + 1);

   // Trend sums: 32-bit sample times 17-bit weight, summed over the window
   localparam int ACC_W  = 49 + $clog2(WINDOW);
   localparam int TOT_W  = 17 + $clog2(WINDOW);
   localparam int DCNT_W = $clog2(ACC_W + 1);

   localparam logic [24:0] ONE_Q24 = 25'd16777216;

   // Register reset values
   localparam logic [24:0] OMEGA_RST   = 25'd168;
   localparam logic [24:0] ALPHA_RST   = 25'd1677722;
   localparam logic [24:0] BETA_RST    = 25'd13421773;
   localparam logic [30:0] FLOOR_RST   = 31'd1678;
   localparam logic [30:0] CEILING_RST = 31'd83886080;
   localparam logic [24:0] DECAY_RST   = 25'd15938355;
   localparam logic [31:0] LAST_VOL_RST = 32'd167772;

   // Register indexes
   localparam logic [2:0] REG_OMEGA   = 3'd0;
   localparam logic [2:0] REG_ALPHA   = 3'd1;
   localparam logic [2:0] REG_BETA    = 3'd2;
   localparam logic [2:0] REG_FLOOR   = 3'd3;
   localparam logic [2:0] REG_CEILING = 3'd4;
   localparam logic [2:0] REG_DECAY   = 3'd5;

   // Divider control and status
   typedef struct packed {
      logic start;
   } div_ctrl_type;

   typedef struct packed {
      logic busy;
      logic done;
   } div_stat_type;

   // Sequencer states
   typedef enum logic [13:0] {
      S_IDLE  = 14'b00000000000001,
      S_RSQ   = 14'b00000000000010,
      S_RALO  = 14'b00000000000100,
      S_RAHI  = 14'b00000000001000,
      S_RADD  = 14'b00000000010000,
      S_LSQ   = 14'b00000000100000,
      S_LBLO  = 14'b00000001000000,
      S_LBHI  = 14'b00000010000000,
      S_LADD  = 14'b00000100000000,
      S_SQRT  = 14'b00001000000000,
      S_CLAMP = 14'b00010000000000,
      S_WALK  = 14'b00100000000000,
      S_DIV   = 14'b01000000000000,
      S_OUT   = 14'b10000000000000
   } state_type;

   // Unsigned 64-bit add that saturates at all ones
   function automatic logic [63:0] sat_add(input logic [63:0] a, input logic [63:0] b);
      logic [64:0] s;
      s = {1'b0, a} + {1'b0, b};
      return s[64] ? {64{1'b1}} : s[63:0];
   endfunction

   // Join split partial products, wrapping at 64 bits
   function automatic logic [63:0] join_term(input logic [44:0] hi, input logic [44:0] lo);
      logic [65:0] s;
      s = {1'b0, hi, 20'd0} + {21'd0, lo};
      return s[63:0];
   endfunction

endpackage
`default_nettype wire

>>> hw/rtl/return_volatility_and_trend_unit.sv
// One request is handled at a time, from acceptance to response valid: the variance
// multiplies, a 32-step square root, one ring memory read per entry for the trend, and a
// one-bit-per-cycle divider make up the work; the result register frees the input side
// while a response waits.
// Reset clears registers to defaults, last volatility to 0.01, the write slot to zero and
// marks every ring entry invalid so it reads as zero; no clearing pass is needed.
`default_nettype none
module return_volatility_and_trend_unit (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic signed [31:0] req_return_sample,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic [31:0]      rsp_volatility,
   output logic signed [31:0] rsp_trend,
   input  wire logic        psel,
   input  wire logic        penable,
   input  wire logic        pwrite,
   input  wire logic [4:0]  paddr,
   input  wire logic [31:0] pwdata,
   output logic [31:0]      prdata,
   output logic             pready
);

   rvt_pkg::state_type state_ff, state_in;

   // Configuration registers
   logic [24:0] omega_ff, alpha_ff, beta_ff, decay_ff;
   logic [30:0] floor_ff, ceiling_ff;
   logic [2:0]  reg_idx;
   logic        cfg_wr;

   // Ring memory and its valid bits
   logic [31:0]                ring [rvt_pkg::WINDOW];
   logic [rvt_pkg::WINDOW-1:0] ring_vld_ff;
   logic [31:0]                ring_q_ff;
   logic                       vld_q_ff;

   logic [rvt_pkg::SLOT_W-1:0] slot_ff, slot_in;
   logic [rvt_pkg::SLOT_W-1:0] rd_addr_ff, rd_addr_in;
   logic [31:0]                last_vol_ff, last_vol_in;

   // Variance datapath
   logic [31:0] mag_ff, mag_in;
   logic [63:0] sq_ff, sq_in;
   logic [44:0] plo_ff, plo_in, phi_ff, phi_in;
   logic [63:0] var_ff, var_in;
   logic [63:0] x_ff, x_in, res_ff, res_in, bit_ff, bit_in;
   logic [31:0] vol_ff, vol_in;
   logic [39:0] sq_top;
   logic [24:0] mul_b;
   logic [63:0] sq_sum;

   // Trend datapath
   logic [rvt_pkg::CNT_W-1:0]        cnt_ff, cnt_in;
   logic [24:0]                      w_ff, w_in;
   logic [16:0]                      wq1_ff, wq1_in;
   logic                             p1_ff, p1_in, p2_ff, p2_in;
   logic signed [rvt_pkg::ACC_W-1:0] prod_ff, prod_in;
   logic signed [rvt_pkg::ACC_W-1:0] acc_ff, acc_in;
   logic [rvt_pkg::TOT_W-1:0]        total_ff, total_in;
   logic [24:0]                      decay_eff;
   logic [49:0]                      w_prod;
   logic                             issue;
   logic signed [31:0]               tap;
   logic signed [50:0]               tap_prod;

   // Output register
   logic        rsp_valid_ff, rsp_valid_in;
   logic [31:0] rsp_vol_ff, rsp_vol_in;
   logic [31:0] rsp_trend_ff, rsp_trend_in;
   logic [31:0] trend_ff, trend_in;

   rvt_pkg::div_ctrl_type div_ctrl;
   rvt_pkg::div_stat_type div_stat;
   logic [31:0]           div_q;

   logic accept;
   logic rsp_free;

   assign accept   = req_valid && !req_stall;
   assign rsp_free = !rsp_valid_ff || !rsp_stall;

   // Configuration port
   assign pready  = 1'b1;
   assign reg_idx = paddr[4:2];
   assign cfg_wr  = psel && penable && pwrite;

   always_comb begin
      case (reg_idx)
         rvt_pkg::REG_OMEGA:   prdata = {7'd0, omega_ff};
         rvt_pkg::REG_ALPHA:   prdata = {7'd0, alpha_ff};
         rvt_pkg::REG_BETA:    prdata = {7'd0, beta_ff};
         rvt_pkg::REG_FLOOR:   prdata = {1'b0, floor_ff};
         rvt_pkg::REG_CEILING: prdata = {1'b0, ceiling_ff};
         rvt_pkg::REG_DECAY:   prdata = {7'd0, decay_ff};
         default:              prdata = 32'd0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         omega_ff   <= rvt_pkg::OMEGA_RST;
         alpha_ff   <= rvt_pkg::ALPHA_RST;
         beta_ff    <= rvt_pkg::BETA_RST;
         floor_ff   <= rvt_pkg::FLOOR_RST;
         ceiling_ff <= rvt_pkg::CEILING_RST;
         decay_ff   <= rvt_pkg::DECAY_RST;
      end else if (cfg_wr) begin
         case (reg_idx)
            rvt_pkg::REG_OMEGA:   omega_ff   <= pwdata[24:0];
            rvt_pkg::REG_ALPHA:   alpha_ff   <= pwdata[24:0];
            rvt_pkg::REG_BETA:    beta_ff    <= pwdata[24:0];
            rvt_pkg::REG_FLOOR:   floor_ff   <= pwdata[30:0];
            rvt_pkg::REG_CEILING: ceiling_ff <= pwdata[30:0];
            rvt_pkg::REG_DECAY:   decay_ff   <= pwdata[24:0];
            default: ;
         endcase
      end
   end

   // Ring memory: write on accept, read one entry a cycle during the walk
   always_ff @(posedge clock) begin
      if (accept) begin
         ring[slot_ff] <= req_return_sample;
      end
      ring_q_ff <= ring[rd_addr_ff];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ring_vld_ff <= '0;
         vld_q_ff    <= 1'b0;
      end else begin
         if (accept) begin
            ring_vld_ff[slot_ff] <= 1'b1;
         end
         vld_q_ff <= ring_vld_ff[rd_addr_ff];
      end
   end

   // Shared datapath helpers
   assign sq_top    = sq_ff[63:24];
   assign mul_b     = (state_ff == rvt_pkg::S_RALO || state_ff == rvt_pkg::S_RAHI)
                      ? alpha_ff : beta_ff;
   assign sq_sum    = res_ff + bit_ff;
   assign decay_eff = (decay_ff > rvt_pkg::ONE_Q24) ? rvt_pkg::ONE_Q24 : decay_ff;
   assign w_prod    = w_ff * decay_eff;
   assign issue     = (cnt_ff != rvt_pkg::CNT_W'(rvt_pkg::WINDOW));
   assign tap       = vld_q_ff ? $signed(ring_q_ff) : 32'sd0;
   assign tap_prod  = tap * $signed({1'b0, wq1_ff});

   // Sequencer
   always_comb begin
      state_in     = state_ff;
      slot_in      = slot_ff;
      rd_addr_in   = rd_addr_ff;
      last_vol_in  = last_vol_ff;
      mag_in       = mag_ff;
      sq_in        = sq_ff;
      plo_in       = plo_ff;
      phi_in       = phi_ff;
      var_in       = var_ff;
      x_in         = x_ff;
      res_in       = res_ff;
      bit_in       = bit_ff;
      vol_in       = vol_ff;
      cnt_in       = cnt_ff;
      w_in         = w_ff;
      wq1_in       = wq1_ff;
      p1_in        = 1'b0;
      p2_in        = 1'b0;
      prod_in      = prod_ff;
      acc_in       = acc_ff;
      total_in     = total_ff;
      trend_in     = trend_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_vol_in   = rsp_vol_ff;
      rsp_trend_in = rsp_trend_ff;
      div_ctrl.start = 1'b0;
      case (state_ff)
         rvt_pkg::S_IDLE: begin
            if (req_valid) begin
               mag_in     = req_return_sample[31] ? (~req_return_sample + 1'b1)
                                                  : req_return_sample;
               rd_addr_in = slot_ff;
               slot_in    = (slot_ff == rvt_pkg::SLOT_W'(rvt_pkg::WINDOW - 1))
                            ? '0 : slot_ff + 1'b1;
               state_in   = rvt_pkg::S_RSQ;
            end
         end
         rvt_pkg::S_RSQ: begin
            sq_in    = mag_ff * mag_ff;
            state_in = rvt_pkg::S_RALO;
         end
         rvt_pkg::S_RALO: begin
            plo_in   = sq_top[19:0] * mul_b;
            state_in = rvt_pkg::S_RAHI;
         end
         rvt_pkg::S_RAHI: begin
            phi_in   = sq_top[39:20] * mul_b;
            state_in = rvt_pkg::S_RADD;
         end
         rvt_pkg::S_RADD: begin
            var_in   = rvt_pkg::sat_add({15'd0, omega_ff, 24'd0},
                                        rvt_pkg::join_term(phi_ff, plo_ff));
            state_in = rvt_pkg::S_LSQ;
         end
         rvt_pkg::S_LSQ: begin
            sq_in    = last_vol_ff * last_vol_ff;
            state_in = rvt_pkg::S_LBLO;
         end
         rvt_pkg::S_LBLO: begin
            plo_in   = sq_top[19:0] * mul_b;
            state_in = rvt_pkg::S_LBHI;
         end
         rvt_pkg::S_LBHI: begin
            phi_in   = sq_top[39:20] * mul_b;
            state_in = rvt_pkg::S_LADD;
         end
         rvt_pkg::S_LADD: begin
            x_in     = rvt_pkg::sat_add(var_ff, rvt_pkg::join_term(phi_ff, plo_ff));
            res_in   = '0;
            bit_in   = 64'd1 << 62;
            state_in = rvt_pkg::S_SQRT;
         end
         rvt_pkg::S_SQRT: begin
            // one result bit per cycle
            if (x_ff >= sq_sum) begin
               x_in   = x_ff - sq_sum;
               res_in = (res_ff >> 1) + bit_ff;
            end else begin
               res_in = res_ff >> 1;
            end
            bit_in = bit_ff >> 2;
            if (bit_ff[0]) begin
               state_in = rvt_pkg::S_CLAMP;
            end
         end
         rvt_pkg::S_CLAMP: begin
            vol_in = res_ff[31:0];
            if (res_ff[31:0] < {1'b0, floor_ff}) begin
               last_vol_in = {1'b0, floor_ff};
            end else begin
               last_vol_in = res_ff[31:0];
            end
            if (last_vol_in > {1'b0, ceiling_ff}) begin
               last_vol_in = {1'b0, ceiling_ff};
            end
            cnt_in   = '0;
            w_in     = rvt_pkg::ONE_Q24;
            acc_in   = '0;
            total_in = '0;
            state_in = rvt_pkg::S_WALK;
         end
         rvt_pkg::S_WALK: begin
            // issue one ring read per cycle, newest first
            if (issue) begin
               wq1_in     = w_ff[24:8];
               total_in   = total_ff + rvt_pkg::TOT_W'(w_ff[24:8]);
               w_in       = w_prod[48:24];
               cnt_in     = cnt_ff + 1'b1;
               rd_addr_in = (rd_addr_ff == '0) ? rvt_pkg::SLOT_W'(rvt_pkg::WINDOW - 1)
                                               : rd_addr_ff - 1'b1;
               p1_in      = 1'b1;
            end
            if (p1_ff) begin
               prod_in = rvt_pkg::ACC_W'(tap_prod);
               p2_in   = 1'b1;
            end
            if (p2_ff) begin
               acc_in = acc_ff + prod_ff;
            end
            if (!issue && !p1_ff && !p2_ff) begin
               div_ctrl.start = 1'b1;
               state_in       = rvt_pkg::S_DIV;
            end
         end
         rvt_pkg::S_DIV: begin
            if (div_stat.done) begin
               trend_in = div_q;
               state_in = rvt_pkg::S_OUT;
            end
         end
         rvt_pkg::S_OUT: begin
            // hold until the response register is free
            if (rsp_free) begin
               rsp_valid_in = 1'b1;
               rsp_vol_in   = vol_ff;
               rsp_trend_in = trend_ff;
               state_in     = rvt_pkg::S_IDLE;
            end
         end
         default: begin
            state_in = rvt_pkg::S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= rvt_pkg::S_IDLE;
         slot_ff      <= '0;
         last_vol_ff  <= rvt_pkg::LAST_VOL_RST;
         p1_ff        <= 1'b0;
         p2_ff        <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         slot_ff      <= slot_in;
         last_vol_ff  <= last_vol_in;
         p1_ff        <= p1_in;
         p2_ff        <= p2_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rd_addr_ff   <= rd_addr_in;
      mag_ff       <= mag_in;
      sq_ff        <= sq_in;
      plo_ff       <= plo_in;
      phi_ff       <= phi_in;
      var_ff       <= var_in;
      x_ff         <= x_in;
      res_ff       <= res_in;
      bit_ff       <= bit_in;
      vol_ff       <= vol_in;
      cnt_ff       <= cnt_in;
      w_ff         <= w_in;
      wq1_ff       <= wq1_in;
      prod_ff      <= prod_in;
      acc_ff       <= acc_in;
      total_ff     <= total_in;
      trend_ff     <= trend_in;
      rsp_vol_ff   <= rsp_vol_in;
      rsp_trend_ff <= rsp_trend_in;
   end

   // Trend division
   rvt_divider u_divider (
      .clock    (clock),
      .reset    (reset),
      .ctrl     (div_ctrl),
      .dividend (acc_ff),
      .divisor  (total_ff),
      .stat     (div_stat),
      .quotient (div_q)
   );

   assign req_stall      = (state_ff != rvt_pkg::S_IDLE);
   assign rsp_valid      = rsp_valid_ff;
   assign rsp_volatility = rsp_vol_ff;
   assign rsp_trend      = rsp_trend_ff;

endmodule
`default_nettype wire

>>> hw/rtl/rvt_divider.sv
// Iterative signed-by-unsigned divider, one quotient bit per cycle, truncating toward zero.
`default_nettype none
module rvt_divider (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire rvt_pkg::div_ctrl_type         ctrl,
   input  wire logic signed [rvt_pkg::ACC_W-1:0] dividend,
   input  wire logic [rvt_pkg::TOT_W-1:0]     divisor,
   output rvt_pkg::div_stat_type              stat,
   output logic [31:0]                        quotient
);

   logic                        busy_ff, busy_in;
   logic                        done_ff, done_in;
   logic                        neg_ff, neg_in;
   logic [rvt_pkg::DCNT_W-1:0]  cnt_ff, cnt_in;
   logic [rvt_pkg::ACC_W-1:0]   num_ff, num_in;
   logic [rvt_pkg::TOT_W-1:0]   rem_ff, rem_in;
   logic [rvt_pkg::TOT_W-1:0]   den_ff, den_in;
   logic [31:0]                 quot_ff, quot_in;
   logic [rvt_pkg::TOT_W:0]     rem_sh;
   logic [rvt_pkg::ACC_W-1:0]   mag;
   logic [rvt_pkg::ACC_W-1:0]   q_signed;

   assign mag      = dividend[rvt_pkg::ACC_W-1] ? (~dividend + 1'b1) : dividend;
   assign rem_sh   = {rem_ff, num_ff[rvt_pkg::ACC_W-1]};
   assign q_signed = neg_ff ? (~num_ff + 1'b1) : num_ff;

   // Shift and subtract one bit per cycle
   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      neg_in  = neg_ff;
      cnt_in  = cnt_ff;
      num_in  = num_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      quot_in = quot_ff;
      if (ctrl.start) begin
         busy_in = 1'b1;
         neg_in  = dividend[rvt_pkg::ACC_W-1];
         num_in  = mag;
         rem_in  = '0;
         den_in  = divisor;
         cnt_in  = rvt_pkg::DCNT_W'(rvt_pkg::ACC_W);
      end else if (busy_ff) begin
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
            quot_in = q_signed[31:0];
         end else begin
            if (rem_sh >= {1'b0, den_ff}) begin
               rem_in = rvt_pkg::TOT_W'(rem_sh - {1'b0, den_ff});
               num_in = {num_ff[rvt_pkg::ACC_W-2:0], 1'b1};
            end else begin
               rem_in = rem_sh[rvt_pkg::TOT_W-1:0];
               num_in = {num_ff[rvt_pkg::ACC_W-2:0], 1'b0};
            end
            cnt_in = cnt_ff - 1'b1;
         end
      end
   end

   // Hold control under reset, payload free
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      neg_ff  <= neg_in;
      cnt_ff  <= cnt_in;
      num_ff  <= num_in;
      rem_ff  <= rem_in;
      den_ff  <= den_in;
      quot_ff <= quot_in;
   end

   assign stat.busy = busy_ff;
   assign stat.done = done_ff;
   assign quotient  = quot_ff;

endmodule
`default_nettype wire
